FILE: design/ngo_pkg.sv
`timescale 1ns / 1ps
package ngo_pkg;

  // Geometry of the table
  localparam int MAX_AXES     = 4;
  localparam int CELLS        = 4096;
  localparam int PAYLOAD_BITS = 32;

  localparam int IDX_W   = $clog2(CELLS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int AX_W    = $clog2(MAX_AXES);
  localparam int AXC_W   = 3;
  localparam int DIM_W   = 13;
  localparam int COORD_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_3      = 3'd4;

  // Request types
  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_GET   = 1'b1;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BOUNDS   = 3'd1,
    STS_OCCUPIED = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_CAPACITY = 3'd4
  } ngo_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_READ,
    S_COMMIT
  } ngo_state_t;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic [PAYLOAD_BITS-1:0]   payload_in;
  } ngo_in_t;

  typedef struct packed {
    ngo_status_t             status;
    logic [IDX_W-1:0]        cell_index;
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [CNT_W-1:0]        filled_count;
  } ngo_out_t;

  // Controller to datapath
  typedef struct packed {
    logic            clr;
    logic            load;
    logic            step;
    logic [AX_W-1:0] axis;
    logic            read;
    logic            commit;
  } ngo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [AX_W-1:0] last_axis;
    logic            clr_last;
    logic            out_busy;
  } ngo_sts_t;

endpackage

FILE: design/ngo_ctrl.sv
`timescale 1ns / 1ps
module ngo_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ngo_pkg::ngo_sts_t sts,
  output ngo_pkg::ngo_cmd_t cmd
);
  import ngo_pkg::*;

  ngo_state_t      state_r, state_nxt;
  logic [AX_W-1:0] ax_r, ax_nxt;

  // Hold state and axis counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_STEP;
          ax_nxt    = '0;
        end
      end
      S_STEP: begin
        if (ax_r == sts.last_axis) state_nxt = S_READ;
        else ax_nxt = ax_r + AX_W'(1);
      end
      S_READ: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.axis = ax_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_STEP:   cmd.step = 1'b1;
      S_READ:   cmd.read = 1'b1;
      S_COMMIT: cmd.commit = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

  // Only one phase of the sequence at a time
  a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !(cmd.load || cmd.step || cmd.read || cmd.commit))
    else $error("clearing pass overlaps a request");

  a_step_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.step && cmd.axis == '0)
    else $error("first axis step does not follow load");

  a_read_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |=> state_r == S_COMMIT)
    else $error("memory read not followed by commit phase");

endmodule

FILE: design/ngo_datapath.sv
`timescale 1ns / 1ps
module ngo_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ngo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ngo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ngo_pkg::ngo_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ngo_pkg::ngo_out_t              out_data,
  input  ngo_pkg::ngo_cmd_t              cmd,
  output ngo_pkg::ngo_sts_t              sts
);
  import ngo_pkg::*;

  localparam int PROD_W = IDX_W + DIM_W;
  localparam int SUM_W  = PROD_W + 1;

  // Configuration registers
  logic [AXC_W-1:0] axis_count_r;
  logic [DIM_W-1:0] dim_r [MAX_AXES];

  // Request and index state
  ngo_in_t          req_r;
  logic [IDX_W-1:0] flat_r;
  logic             bnd_r;
  logic             ovf_r;

  // Memories and their read registers
  logic                    occ_mem [CELLS];
  logic [PAYLOAD_BITS-1:0] pay_mem [CELLS];
  logic                    occ_q_r;
  logic [PAYLOAD_BITS-1:0] pay_q_r;

  logic [IDX_W-1:0] clr_addr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  ngo_out_t         out_r;

  logic [AX_W-1:0]    last_axis;
  logic [COORD_W-1:0] raw;
  logic [DIM_W-1:0]   dimv;
  logic               fail;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum;
  logic               is_place;
  logic               do_write;
  ngo_out_t           res;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= AXC_W'(1);
      dim_r[0]     <= DIM_W'(CELLS);
      dim_r[1]     <= DIM_W'(1);
      dim_r[2]     <= DIM_W'(1);
      dim_r[3]     <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_AXIS_COUNT: axis_count_r <= cfg_data[AXC_W-1:0];
        CFG_DIM_0:      dim_r[0] <= cfg_data[DIM_W-1:0];
        CFG_DIM_1:      dim_r[1] <= cfg_data[DIM_W-1:0];
        CFG_DIM_2:      dim_r[2] <= cfg_data[DIM_W-1:0];
        CFG_DIM_3:      dim_r[3] <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the axis count to the supported range
  always_comb begin
    unique case (axis_count_r) inside
      3'd0, 3'd1: last_axis = AX_W'(0);
      3'd2:       last_axis = AX_W'(1);
      3'd3:       last_axis = AX_W'(2);
      default:    last_axis = AX_W'(MAX_AXES - 1);
    endcase
  end

  // Select the coordinate of the current axis
  always_comb begin
    case (cmd.axis)
      2'd0:    raw = unsigned'(req_r.coord_0);
      2'd1:    raw = unsigned'(req_r.coord_1);
      2'd2:    raw = unsigned'(req_r.coord_2);
      default: raw = unsigned'(req_r.coord_3);
    endcase
  end

  // One Horner step: bounds check and multiply-add
  assign dimv = dim_r[cmd.axis];
  assign fail = raw[COORD_W-1] || (raw >= COORD_W'(dimv));
  assign prod = PROD_W'(flat_r) * PROD_W'(dimv);
  assign sum  = SUM_W'(prod) + SUM_W'(raw);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_data;
      flat_r <= '0;
      bnd_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (cmd.step && !bnd_r) begin
      if (fail) begin
        bnd_r <= 1'b1;
      end else if (!ovf_r) begin
        if (sum >= SUM_W'(CELLS)) ovf_r <= 1'b1;
        else flat_r <= sum[IDX_W-1:0];
      end
    end
  end

  // Work out the result of the request
  assign is_place = (req_r.req_type == REQ_PLACE);
  assign do_write = cmd.commit && !bnd_r && !ovf_r && is_place && !occ_q_r;

  always_comb begin
    res              = '0;
    res.filled_count = cnt_r;
    if (bnd_r) begin
      res.status = STS_BOUNDS;
    end else if (ovf_r) begin
      res.status = STS_CAPACITY;
    end else begin
      res.cell_index = flat_r;
      if (is_place) begin
        if (occ_q_r) begin
          res.status = STS_OCCUPIED;
        end else begin
          res.status       = STS_OK;
          res.filled_count = cnt_r + CNT_W'(1);
        end
      end else if (occ_q_r) begin
        res.status      = STS_OK;
        res.payload_out = pay_q_r;
      end else begin
        res.status = STS_EMPTY;
      end
    end
  end

  // Occupancy memory: clearing pass, then set on placement
  always_ff @(posedge clk) begin
    if (cmd.clr) occ_mem[clr_addr_r] <= 1'b0;
    else if (do_write) occ_mem[flat_r] <= 1'b1;
    if (cmd.read) occ_q_r <= occ_mem[flat_r];
  end

  // Payload memory
  always_ff @(posedge clk) begin
    if (do_write) pay_mem[flat_r] <= req_r.payload_in;
    if (cmd.read) pay_q_r <= pay_mem[flat_r];
  end

  // Advance clear address and filled count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (do_write) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register: load on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= res;
  end

  assign sts.last_axis = last_axis;
  assign sts.clr_last  = (clr_addr_r == IDX_W'(CELLS - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not present a result");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_ready))
    else $error("commit would overwrite a pending result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("filled count did not advance on placement");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CELLS))
    else $error("filled count beyond table size");

endmodule

FILE: design/nd_grid_occupancy_table.sv
`timescale 1ns / 1ps
// Grid occupancy table with row-major addressing of up to four axes. After
// reset the block runs a clearing pass over the 4096-entry occupancy memory,
// during which no request is taken (configuration writes are taken
// throughout). Requests are handled one at a time, and each passes through
// an accept step, a step for each axis in use through the single shared
// multiply-add that forms the index, the registered memory read and the
// check and write-back. A finished result waits in the output register while
// the next request is taken in; the write-back of that next request stalls
// until the waiting result has been transferred.
module nd_grid_occupancy_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ngo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ngo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ngo_pkg::ngo_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ngo_pkg::ngo_out_t              out_data
);
  import ngo_pkg::*;

  ngo_cmd_t cmd;
  ngo_sts_t sts;

  // Sequencer
  ngo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Index arithmetic, memories and result register
  ngo_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
